### rtl/fmd_pkg.sv
// Shared types and constants of the framed message deframer.
`timescale 1ns / 1ps
`default_nettype none

package fmd_pkg;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;
    localparam logic [4:0] MIN_PACKET = 5'd17;

    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SUPPORTED_VERSION = t_cfg_idx'(0);
    localparam t_cfg_idx REG_IGNORE_MASK = t_cfg_idx'(1);

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_ORIGIN  = 3'd1,
        ROLE_REMOTE  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_TRAIL   = 3'd4
    } t_role;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_PACKET   = 2'd1,
        ST_BAD_VERSION  = 2'd2,
        ST_BAD_CHECKSUM = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] supported_version;
        logic [7:0] ignore_checksum_mask;
    } t_cfg;

    typedef struct packed {
        t_role       byte_role;
        logic [7:0]  out_byte;
        logic        packet_done;
        t_status     status;
        logic [7:0]  origin_length;
        logic [7:0]  remote_length;
        logic [7:0]  ttl_value;
        logic [7:0]  options_value;
        logic [63:0] payload_length;
    } t_result;

endpackage

`default_nettype wire

### rtl/fmd_if.sv
// Channel interfaces: byte input, tagged result output and register write.
`timescale 1ns / 1ps
`default_nettype none

interface fmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface fmd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic [7:0]  out_byte;
    logic        packet_done;
    logic [1:0]  status;
    logic [7:0]  origin_length;
    logic [7:0]  remote_length;
    logic [7:0]  ttl_value;
    logic [7:0]  options_value;
    logic [63:0] payload_length;

    modport source (
        output valid, input ready,
        output byte_role, output out_byte, output packet_done, output status,
        output origin_length, output remote_length, output ttl_value,
        output options_value, output payload_length
    );
    modport sink (
        input valid, output ready,
        input byte_role, input out_byte, input packet_done, input status,
        input origin_length, input remote_length, input ttl_value,
        input options_value, input payload_length
    );
endinterface

interface fmd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/fmd_parse.sv
// Packet parser: phase state, header registers, running XOR and status logic.
`timescale 1ns / 1ps
`default_nettype none

module fmd_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    input  wire fmd_pkg::t_cfg    i_cfg,
    output fmd_pkg::t_result      o_result
);
    import fmd_pkg::*;

    typedef enum logic [3:0] {
        PH_SOH     = 4'd0,
        PH_VER     = 4'd1,
        PH_OLEN    = 4'd2,
        PH_ORIGIN  = 4'd3,
        PH_RLEN    = 4'd4,
        PH_REMOTE  = 4'd5,
        PH_TTL     = 4'd6,
        PH_LEN     = 4'd7,
        PH_OPT     = 4'd8,
        PH_CHK     = 4'd9,
        PH_STX     = 4'd10,
        PH_PAYLOAD = 4'd11,
        PH_TRAIL   = 4'd12
    } t_phase;

    typedef struct packed {
        logic soh;
        logic stx;
        logic ver;
    } t_err;

    t_phase      r_phase, n_phase;
    logic [63:0] r_fc, n_fc;
    logic [7:0]  r_olen, n_olen;
    logic [7:0]  r_rlen, n_rlen;
    logic [7:0]  r_ttl, n_ttl;
    logic [7:0]  r_opt, n_opt;
    logic [63:0] r_len, n_len;
    logic [7:0]  r_check, n_check;
    logic [7:0]  r_xor, n_xor;
    t_err        r_err, n_err;
    logic [4:0]  r_pkt, n_pkt;

    logic [63:0] fc_dec;
    logic        in_trail;
    t_role       role;
    t_status     status;

    always_comb begin
        n_phase  = r_phase;
        n_fc     = r_fc;
        n_olen   = r_olen;
        n_rlen   = r_rlen;
        n_ttl    = r_ttl;
        n_opt    = r_opt;
        n_len    = r_len;
        n_check  = r_check;
        n_xor    = r_xor ^ i_byte;
        n_err    = r_err;
        n_pkt    = (r_pkt < MIN_PACKET) ? r_pkt + 5'd1 : r_pkt;
        fc_dec   = r_fc - 64'd1;
        in_trail = 1'b0;
        role     = ROLE_HEADER;
        case (r_phase)
            PH_SOH: begin
                if (i_byte != SOH_BYTE) begin
                    n_err.soh = 1'b1;
                end
                n_phase = PH_VER;
            end
            PH_VER: begin
                if (i_byte != i_cfg.supported_version) begin
                    n_err.ver = 1'b1;
                end
                n_phase = PH_OLEN;
            end
            PH_OLEN: begin
                n_olen  = i_byte;
                n_fc    = {56'd0, i_byte};
                n_phase = (i_byte != 8'd0) ? PH_ORIGIN : PH_RLEN;
            end
            PH_ORIGIN: begin
                role = ROLE_ORIGIN;
                n_fc = fc_dec;
                if (fc_dec == 64'd0) begin
                    n_phase = PH_RLEN;
                end
            end
            PH_RLEN: begin
                n_rlen  = i_byte;
                n_fc    = {56'd0, i_byte};
                n_phase = (i_byte != 8'd0) ? PH_REMOTE : PH_TTL;
            end
            PH_REMOTE: begin
                role = ROLE_REMOTE;
                n_fc = fc_dec;
                if (fc_dec == 64'd0) begin
                    n_phase = PH_TTL;
                end
            end
            PH_TTL: begin
                n_ttl   = i_byte;
                n_fc    = 64'd8;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len = {r_len[55:0], i_byte};
                n_fc  = fc_dec;
                if (fc_dec == 64'd0) begin
                    n_phase = PH_OPT;
                end
            end
            PH_OPT: begin
                n_opt   = i_byte;
                n_phase = PH_CHK;
            end
            PH_CHK: begin
                n_xor   = r_xor;
                n_check = i_byte;
                n_phase = PH_STX;
            end
            PH_STX: begin
                if (i_byte != STX_BYTE) begin
                    n_err.stx = 1'b1;
                end
                n_fc    = r_len;
                n_phase = (r_len != 64'd0) ? PH_PAYLOAD : PH_TRAIL;
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                n_fc = fc_dec;
                if (fc_dec == 64'd0) begin
                    n_phase = PH_TRAIL;
                end
            end
            default: begin
                // Trailing bytes, and any unused phase code, are not checked.
                n_xor    = r_xor;
                in_trail = 1'b1;
                role     = i_last ? ROLE_HEADER : ROLE_TRAIL;
            end
        endcase
    end

    always_comb begin
        if (n_pkt < MIN_PACKET) begin
            status = ST_BAD_PACKET;
        end else if (n_err.soh || i_byte != ETX_BYTE) begin
            status = ST_BAD_PACKET;
        end else if (n_err.ver) begin
            status = ST_BAD_VERSION;
        end else if (!in_trail || n_err.stx) begin
            status = ST_BAD_PACKET;
        end else if ((n_opt & i_cfg.ignore_checksum_mask) == 8'd0 &&
                     (n_xor ^ ETX_BYTE) != n_check) begin
            status = ST_BAD_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result.byte_role      = role;
        o_result.out_byte       = i_byte;
        o_result.packet_done    = i_last;
        o_result.status         = i_last ? status : ST_OK;
        o_result.origin_length  = i_last ? n_olen : 8'd0;
        o_result.remote_length  = i_last ? n_rlen : 8'd0;
        o_result.ttl_value      = i_last ? n_ttl : 8'd0;
        o_result.options_value  = i_last ? n_opt : 8'd0;
        o_result.payload_length = i_last ? n_len : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase <= PH_SOH;
            r_fc    <= 64'd0;
            r_olen  <= 8'd0;
            r_rlen  <= 8'd0;
            r_ttl   <= 8'd0;
            r_opt   <= 8'd0;
            r_len   <= 64'd0;
            r_check <= 8'd0;
            r_xor   <= 8'd0;
            r_err   <= '0;
            r_pkt   <= 5'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_olen  <= n_olen;
            r_rlen  <= n_rlen;
            r_ttl   <= n_ttl;
            r_opt   <= n_opt;
            r_len   <= n_len;
            r_check <= n_check;
            r_xor   <= n_xor;
            r_err   <= n_err;
            r_pkt   <= n_pkt;
        end
    end

endmodule

`default_nettype wire

### rtl/fmd_out_reg.sv
// Result register that holds one tagged beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module fmd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire fmd_pkg::t_result i_result,
    output logic                  o_can_load,
    fmd_out_if.source             o_out
);
    import fmd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.byte_role      = r_result.byte_role;
    assign o_out.out_byte       = r_result.out_byte;
    assign o_out.packet_done    = r_result.packet_done;
    assign o_out.status         = r_result.status;
    assign o_out.origin_length  = r_result.origin_length;
    assign o_out.remote_length  = r_result.remote_length;
    assign o_out.ttl_value      = r_result.ttl_value;
    assign o_out.options_value  = r_result.options_value;
    assign o_out.payload_length = r_result.payload_length;

endmodule

`default_nettype wire

### rtl/framed_message_deframer_core.sv
// Top level of the framed message deframer: register port, parser and result register.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one packet byte per beat and returns one tagged beat for each,
// loaded into the result register as the byte is accepted. It sustains one byte per
// cycle: the parser updates its phase, field counter and running XOR and the result
// register frees itself whenever the consumer takes its beat, so input and output only
// stall each other when the output is back-pressured. The beat carrying the last byte
// also reports the packet status and the parsed header fields, and the parser then
// starts over on the next byte. Registers may be written at any time the block is idle.

module framed_message_deframer_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fmd_in_if.sink    i_in,
    fmd_cfg_if.sink   i_cfg,
    fmd_out_if.source o_out
);
    import fmd_pkg::*;

    t_cfg    r_cfg;
    t_result w_result;
    logic    w_can_load;
    logic    w_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_can_load;
    assign w_accept    = i_in.valid && w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.supported_version    <= 8'd1;
            r_cfg.ignore_checksum_mask <= 8'd1;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_SUPPORTED_VERSION) begin
                r_cfg.supported_version <= i_cfg.data;
            end else if (i_cfg.index == REG_IGNORE_MASK) begin
                r_cfg.ignore_checksum_mask <= i_cfg.data;
            end
        end
    end

    fmd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.last_byte),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    fmd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

### verif/tb_framed_message_deframer_core.sv
// Self-checking testbench of the framed message deframer core.
`timescale 1ns / 1ps

module tb_framed_message_deframer_core;
    import fmd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [3:0] {
        PH_SOH, PH_VER, PH_OLEN, PH_ORIGIN, PH_RLEN, PH_REMOTE, PH_TTL,
        PH_LEN, PH_OPT, PH_CHK, PH_STX, PH_PAYLOAD, PH_TRAIL
    } t_parse_phase;

    typedef enum {
        PK_GOOD, PK_SKIP_CHECK, PK_BAD_CHECK, PK_BAD_SOH, PK_BAD_ETX,
        PK_BAD_VERSION, PK_BAD_STX, PK_CUT, PK_SHORT, PK_NOISE
    } t_pkt_kind;

    class deframe_scoreboard;
        bit [7:0]     version_cfg;
        bit [7:0]     mask_cfg;
        t_parse_phase phase;
        bit [63:0]    field_left;
        bit [7:0]     olen, rlen, ttl, opt, rx_chk, xor_acc;
        bit [63:0]    length;
        bit           bad_soh, bad_stx, bad_ver;
        bit [4:0]     seen;
        t_result      tagged_beats[$];
        int           errors;

        function new();
            version_cfg = 8'h01;
            mask_cfg = 8'h01;
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_SOH;
            field_left = '0;
            olen = '0;
            rlen = '0;
            ttl = '0;
            opt = '0;
            rx_chk = '0;
            xor_acc = '0;
            length = '0;
            bad_soh = 0;
            bad_stx = 0;
            bad_ver = 0;
            seen = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, bit [7:0] value);
            if (idx == REG_SUPPORTED_VERSION) begin
                version_cfg = value;
            end else if (idx == REG_IGNORE_MASK) begin
                mask_cfg = value;
            end
        endfunction

        function void parse_byte(bit [7:0] b, bit last);
            t_result      want;
            t_parse_phase ph;
            ph = phase;
            want = '0;
            want.byte_role = ROLE_HEADER;
            if (seen < MIN_PACKET) seen++;
            if (ph != PH_CHK && ph != PH_TRAIL) xor_acc ^= b;
            case (ph)
                PH_SOH: begin
                    if (b != SOH_BYTE) bad_soh = 1;
                    phase = PH_VER;
                end
                PH_VER: begin
                    if (b != version_cfg) bad_ver = 1;
                    phase = PH_OLEN;
                end
                PH_OLEN: begin
                    olen = b;
                    field_left = 64'(b);
                    phase = (b != 0) ? PH_ORIGIN : PH_RLEN;
                end
                PH_ORIGIN: begin
                    want.byte_role = ROLE_ORIGIN;
                    field_left--;
                    if (field_left == 0) phase = PH_RLEN;
                end
                PH_RLEN: begin
                    rlen = b;
                    field_left = 64'(b);
                    phase = (b != 0) ? PH_REMOTE : PH_TTL;
                end
                PH_REMOTE: begin
                    want.byte_role = ROLE_REMOTE;
                    field_left--;
                    if (field_left == 0) phase = PH_TTL;
                end
                PH_TTL: begin
                    ttl = b;
                    field_left = 64'd8;
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    length = {length[55:0], b};
                    field_left--;
                    if (field_left == 0) phase = PH_OPT;
                end
                PH_OPT: begin
                    opt = b;
                    phase = PH_CHK;
                end
                PH_CHK: begin
                    rx_chk = b;
                    phase = PH_STX;
                end
                PH_STX: begin
                    if (b != STX_BYTE) bad_stx = 1;
                    field_left = length;
                    phase = (length != 0) ? PH_PAYLOAD : PH_TRAIL;
                end
                PH_PAYLOAD: begin
                    want.byte_role = ROLE_PAYLOAD;
                    field_left--;
                    if (field_left == 0) phase = PH_TRAIL;
                end
                default: begin
                    want.byte_role = last ? ROLE_HEADER : ROLE_TRAIL;
                end
            endcase
            want.out_byte = b;
            if (last) begin
                want.packet_done = 1'b1;
                if (seen < MIN_PACKET || bad_soh || b != ETX_BYTE) begin
                    want.status = ST_BAD_PACKET;
                end else if (bad_ver) begin
                    want.status = ST_BAD_VERSION;
                end else if (ph != PH_TRAIL || bad_stx) begin
                    want.status = ST_BAD_PACKET;
                end else if ((opt & mask_cfg) == 0 && (xor_acc ^ ETX_BYTE) != rx_chk) begin
                    want.status = ST_BAD_CHECKSUM;
                end else begin
                    want.status = ST_OK;
                end
                want.origin_length = olen;
                want.remote_length = rlen;
                want.ttl_value = ttl;
                want.options_value = opt;
                want.payload_length = length;
                restart();
            end
            tagged_beats.push_back(want);
        endfunction

        function int field_bad(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (tagged_beats.size() == 0) begin
                $error("result beat with no byte awaiting it: out_byte %0h", got.out_byte);
                errors++;
                return;
            end
            want = tagged_beats.pop_front();
            errors += field_bad("byte_role", want.byte_role, got.byte_role);
            errors += field_bad("out_byte", want.out_byte, got.out_byte);
            errors += field_bad("packet_done", want.packet_done, got.packet_done);
            errors += field_bad("status", want.status, got.status);
            errors += field_bad("origin_length", want.origin_length, got.origin_length);
            errors += field_bad("remote_length", want.remote_length, got.remote_length);
            errors += field_bad("ttl_value", want.ttl_value, got.ttl_value);
            errors += field_bad("options_value", want.options_value, got.options_value);
            errors += field_bad("payload_length", want.payload_length, got.payload_length);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    fmd_in_if  in_if ();
    fmd_out_if out_if ();
    fmd_cfg_if cfg_if ();

    framed_message_deframer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    deframe_scoreboard board = new();
    bit steady = 0;
    int bytes_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : result_sink
        t_result got;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.byte_role = t_role'(out_if.byte_role);
                got.out_byte = out_if.out_byte;
                got.packet_done = out_if.packet_done;
                got.status = t_status'(out_if.status);
                got.origin_length = out_if.origin_length;
                got.remote_length = out_if.remote_length;
                got.ttl_value = out_if.ttl_value;
                got.options_value = out_if.options_value;
                got.payload_length = out_if.payload_length;
                board.check_beat(got);
            end
            @(negedge i_clk);
            out_if.ready = steady || ($urandom_range(0, 99) >= 32);
        end
    end

    function automatic bit [7:0] other_than(bit [7:0] v);
        return v + 8'($urandom_range(1, 255));
    endfunction

    function automatic int pick_size();
        return ($urandom_range(0, 29) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 3);
    endfunction

    function automatic t_pkt_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return PK_GOOD;
        if (r < 55) return PK_SKIP_CHECK;
        if (r < 63) return PK_BAD_CHECK;
        if (r < 68) return PK_BAD_SOH;
        if (r < 73) return PK_BAD_ETX;
        if (r < 79) return PK_BAD_VERSION;
        if (r < 84) return PK_BAD_STX;
        if (r < 92) return PK_CUT;
        if (r < 96) return PK_SHORT;
        return PK_NOISE;
    endfunction

    task automatic send_byte(bit [7:0] b, bit last);
        while (!steady && $urandom_range(0, 99) < 32) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.in_byte = b;
        in_if.last_byte = last;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        board.parse_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [7:0] value);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        board.set_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic drain();
        in_if.valid = 1'b0;
        while (board.tagged_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_packet(t_pkt_kind kind, int olen, int rlen, int n_pay, int n_trail);
        bit [7:0]  pkt[$];
        bit [63:0] decl;
        bit [7:0]  opt;
        bit [7:0]  sum;
        int        chk_pos;
        int        pay_end;
        int        cut;
        decl = 64'(n_pay);
        opt = 8'($urandom);
        if (kind == PK_CUT && $urandom_range(0, 1) == 1) decl = {$urandom, $urandom};
        if (kind == PK_SKIP_CHECK) opt |= board.mask_cfg;
        if (kind == PK_BAD_CHECK) opt &= ~board.mask_cfg;
        pkt.push_back(kind == PK_BAD_SOH ? other_than(SOH_BYTE) : SOH_BYTE);
        pkt.push_back(kind == PK_BAD_VERSION ? other_than(board.version_cfg)
                                             : board.version_cfg);
        pkt.push_back(8'(olen));
        repeat (olen) pkt.push_back(8'($urandom));
        pkt.push_back(8'(rlen));
        repeat (rlen) pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        for (int i = 7; i >= 0; i--) pkt.push_back(decl[8*i +: 8]);
        pkt.push_back(opt);
        chk_pos = pkt.size();
        pkt.push_back(8'h00);
        pkt.push_back(kind == PK_BAD_STX ? other_than(STX_BYTE) : STX_BYTE);
        repeat (n_pay) pkt.push_back(8'($urandom));
        pay_end = pkt.size();
        repeat (n_trail) pkt.push_back(8'($urandom));
        pkt.push_back(kind == PK_BAD_ETX ? other_than(ETX_BYTE) : ETX_BYTE);
        sum = ETX_BYTE;
        for (int i = 0; i < pay_end; i++) begin
            if (i != chk_pos) sum ^= pkt[i];
        end
        if (kind == PK_BAD_CHECK || kind == PK_SKIP_CHECK) sum = other_than(sum);
        pkt[chk_pos] = sum;
        if (kind == PK_CUT || kind == PK_SHORT) begin
            cut = (kind == PK_SHORT) ? $urandom_range(1, 16) : $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
            if (kind == PK_SHORT || $urandom_range(0, 1) == 1) pkt[pkt.size() - 1] = ETX_BYTE;
        end
        if (kind == PK_NOISE) begin
            pkt.delete();
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
        end
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    initial begin : stimulus
        bit [7:0] ver_tab[4];
        bit [7:0] mask_tab[4];
        int       start;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        in_if.last_byte = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_packet(PK_GOOD, 0, 0, 0, 0);
        send_packet(PK_GOOD, 64, 32, 2, 1);
        send_packet(PK_SKIP_CHECK, 1, 2, 1, 0);
        send_packet(PK_BAD_CHECK, 2, 1, 3, 2);
        send_packet(PK_BAD_SOH, 0, 1, 1, 0);
        send_packet(PK_BAD_ETX, 1, 0, 2, 1);
        send_packet(PK_BAD_VERSION, 1, 1, 0, 0);
        send_packet(PK_BAD_STX, 0, 0, 1, 0);
        send_packet(PK_CUT, 2, 2, 4, 0);
        send_packet(PK_SHORT, 0, 0, 0, 0);
        send_packet(PK_NOISE, 0, 0, 0, 0);

        ver_tab = '{8'h00, 8'hFF, 8'($urandom), 8'h01};
        mask_tab = '{8'h00, 8'hFF, 8'($urandom), 8'h80};
        for (int p = 0; p < 4; p++) begin
            drain();
            write_reg(REG_SUPPORTED_VERSION, ver_tab[p]);
            write_reg(REG_IGNORE_MASK, mask_tab[p]);
            steady = (p == 2);
            start = bytes_sent;
            while (bytes_sent - start < 50) begin
                send_packet(pick_kind(), pick_size(), pick_size(), pick_size(),
                            $urandom_range(0, 3));
            end
        end
        steady = 0;
        drain();

        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
